/* hdl/wrh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrh_pkg
// Shared types, constants and binning helpers for the wind rose histogram.
// ----------------------------------------------------------------------------
package wrh_pkg;

    // request opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // defaults for the top level parameters
    localparam int SECTORS_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;

    // fixed number of speed classes
    localparam int SPEED_CLASSES  = 7;

    // full circle in 1/16 degree, split as 45 << 7
    localparam int FULL_CIRCLE    = 5760;
    localparam int DIR_W          = 13;
    localparam int CIRCLE_SHIFT   = 7;
    localparam int CIRCLE_ODD     = FULL_CIRCLE >> CIRCLE_SHIFT;

    // floor(y / 45) as (y * RECIP_M) >> RECIP_K, exact for y below 10000
    localparam int RECIP_K        = 17;
    localparam int RECIP_M        = ((2 ** RECIP_K) + CIRCLE_ODD - 1) / CIRCLE_ODD;
    localparam int RECIP_W        = $clog2(RECIP_M + 1);

    // speed class upper limits in 1/16 unit
    localparam logic signed [15:0] SPD_LIM_0 = 16'sd0;
    localparam logic signed [15:0] SPD_LIM_1 = 16'sd32;
    localparam logic signed [15:0] SPD_LIM_2 = 16'sd48;
    localparam logic signed [15:0] SPD_LIM_3 = 16'sd80;
    localparam logic signed [15:0] SPD_LIM_4 = 16'sd112;
    localparam logic signed [15:0] SPD_LIM_5 = 16'sd144;

    typedef struct packed {
        logic               op;
        logic signed [15:0] speed;
        logic [12:0]        direction;
        logic [3:0]         read_sector;
        logic [2:0]         read_speed_class;
    } t_wrh_req;

    typedef struct packed {
        logic [31:0] count;
        logic [2:0]  speed_class;
        logic [3:0]  sector;
    } t_wrh_rsp;

    function automatic logic [2:0] speed_to_class(input logic signed [15:0] spd);
        logic [2:0] cls;
        if (spd <= SPD_LIM_0) begin
            cls = 3'd0;
        end else if (spd <= SPD_LIM_1) begin
            cls = 3'd1;
        end else if (spd <= SPD_LIM_2) begin
            cls = 3'd2;
        end else if (spd <= SPD_LIM_3) begin
            cls = 3'd3;
        end else if (spd <= SPD_LIM_4) begin
            cls = 3'd4;
        end else if (spd <= SPD_LIM_5) begin
            cls = 3'd5;
        end else begin
            cls = 3'd6;
        end
        return cls;
    endfunction

    // fold directions past a full turn back once
    function automatic logic [DIR_W-1:0] wrap_direction(input logic [DIR_W-1:0] dir);
        logic [DIR_W-1:0] d;
        if (dir >= DIR_W'(FULL_CIRCLE)) begin
            d = dir - DIR_W'(FULL_CIRCLE);
        end else begin
            d = dir;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

/* hdl/wrh_count_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrh_count_store
// Counter memory with one read and one write port, registered read data,
// same-edge write bypass and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module wrh_count_store
    import wrh_pkg::*;
#(
    parameter int NUM_BINS   = SECTORS_DEF * SPEED_CLASSES,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [$clog2(NUM_BINS)-1:0] i_rd_idx,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(NUM_BINS)-1:0] i_wr_idx,
    input  wire logic [COUNT_BITS-1:0]       i_wr_data,
    output logic      [COUNT_BITS-1:0]       o_rd_data,
    output logic                             o_ready
);

    localparam int IDX_W = $clog2(NUM_BINS);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_mem_q;
    logic [COUNT_BITS-1:0] r_byp_data;
    logic                  r_byp;
    logic                  r_clr_busy;
    logic [IDX_W-1:0]      r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(NUM_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // a write on the same edge as the read wins over the stale array word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q    <= r_mem[i_rd_idx];
            r_byp      <= i_wr_en && (i_wr_idx == i_rd_idx);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_mem_q;
    assign o_ready   = !r_clr_busy;

endmodule
`default_nettype wire

/* hdl/wind_rose_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wind_rose_histogram
// Wind rose accumulator: bins speed and direction samples into saturating
// counters and answers counter reads.
// ----------------------------------------------------------------------------
// One request enters per cycle while o_req_stall is low. Its response
// passes the input register, the counter memory read, and the update and
// response register. The counter memory has one read and one write port;
// back to back updates of the same counter are bypassed, so throughput
// stays one per cycle while no stall holds the flow. After reset the block
// zeroes its SECTORS * 7 counters, one per cycle, holding o_req_stall high.
// A read outside the table returns a count of zero and echoes its indices.
module wind_rose_histogram
    import wrh_pkg::*;
#(
    parameter int SECTORS    = SECTORS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    input  wire t_wrh_req i_req,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output t_wrh_rsp      o_rsp
);

    localparam int NUM_BINS  = SECTORS * SPEED_CLASSES;
    localparam int IDX_W     = $clog2(NUM_BINS);
    localparam int SEC_W     = $clog2(SECTORS);
    localparam int X_W       = $clog2(FULL_CIRCLE * SECTORS);
    localparam int Y_W       = X_W - CIRCLE_SHIFT;
    localparam int PROD_W    = Y_W + RECIP_W;
    localparam int WIDE_W    = IDX_W + 4;
    localparam int CNT_EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic adv;
    logic req_acc;
    logic store_ready;

    // stage 1: registered request with class and scaled direction
    logic             r_s1_vld;
    logic             r_s1_op;
    logic [2:0]       r_s1_cls;
    logic [X_W-1:0]   r_s1_x;
    logic [3:0]       r_s1_rsec;

    // stage 2: address issued, waiting on memory data
    logic             r_s2_vld;
    logic             r_s2_op;
    logic             r_s2_hit;
    logic [IDX_W-1:0] r_s2_idx;
    logic [2:0]       r_s2_cls;
    logic [3:0]       r_s2_sec;

    logic             r_out_vld;
    t_wrh_rsp         r_out;

    logic [DIR_W-1:0]  dir_wrapped;
    logic [Y_W-1:0]    y;
    logic [PROD_W-1:0] prod;
    logic [SEC_W-1:0]  q;
    logic [WIDE_W-1:0] q_wide;
    logic [WIDE_W-1:0] add_idx_wide;
    logic [WIDE_W-1:0] rd_idx_wide;
    logic              s1_hit;
    logic [IDX_W-1:0]  n_s2_idx;
    logic [3:0]        n_s2_sec;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] val;
    logic [CNT_EXT_W-1:0]  val_ext;
    logic                  wr_en;
    t_wrh_rsp              n_out;

    assign adv         = !r_out_vld || !i_rsp_stall;
    assign o_req_stall = !adv || !store_ready;
    assign req_acc     = i_req_valid && !o_req_stall;

    assign dir_wrapped = wrap_direction(i_req.direction);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= req_acc;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op   <= i_req.op;
            r_s1_cls  <= (i_req.op == OP_ADD) ? speed_to_class(i_req.speed)
                                              : i_req.read_speed_class;
            r_s1_x    <= X_W'(dir_wrapped) * X_W'(SECTORS);
            r_s1_rsec <= i_req.read_sector;
        end
    end

    // sector = floor(x / 5760) = floor((x >> 7) / 45)
    assign y            = r_s1_x[X_W-1:CIRCLE_SHIFT];
    assign prod         = PROD_W'(y) * PROD_W'(RECIP_M);
    assign q            = prod[RECIP_K +: SEC_W];
    assign q_wide       = WIDE_W'(q);
    assign add_idx_wide = q_wide * WIDE_W'(SPEED_CLASSES) + WIDE_W'(r_s1_cls);
    assign rd_idx_wide  = WIDE_W'(r_s1_rsec) * WIDE_W'(SPEED_CLASSES)
                          + WIDE_W'(r_s1_cls);
    assign s1_hit       = (32'(r_s1_rsec) < SECTORS) && (32'(r_s1_cls) < SPEED_CLASSES);

    always_comb begin
        if (r_s1_op == OP_ADD) begin
            n_s2_idx = add_idx_wide[IDX_W-1:0];
            n_s2_sec = q_wide[3:0];
        end else begin
            n_s2_idx = s1_hit ? rd_idx_wide[IDX_W-1:0] : '0;
            n_s2_sec = r_s1_rsec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_op  <= r_s1_op;
            r_s2_hit <= (r_s1_op == OP_ADD) || s1_hit;
            r_s2_idx <= n_s2_idx;
            r_s2_cls <= r_s1_cls;
            r_s2_sec <= n_s2_sec;
        end
    end

    wrh_count_store #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_idx  (n_s2_idx),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_s2_idx),
        .i_wr_data (inc),
        .o_rd_data (cur),
        .o_ready   (store_ready)
    );

    // saturating increment
    assign inc   = (&cur) ? cur : cur + 1'b1;
    assign wr_en = adv && r_s2_vld && (r_s2_op == OP_ADD);

    always_comb begin
        if (r_s2_op == OP_ADD) begin
            val = inc;
        end else if (r_s2_hit) begin
            val = cur;
        end else begin
            val = '0;
        end
        val_ext           = CNT_EXT_W'(val);
        n_out.count       = val_ext[31:0];
        n_out.speed_class = r_s2_cls;
        n_out.sector      = r_s2_sec;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule
`default_nettype wire

/* tb/wind_rose_histogram_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_rose_histogram_tb
// Drives wind samples and counter reads into the histogram, keeps its own copy
// of the counter table and checks every response field against it. A short
// directed sweep of class limits, sector limits and direction wrap comes
// first, then a random stream in which two hot bins take a large share of
// the samples.
// ----------------------------------------------------------------------------
module wind_rose_histogram_tb;
    import wrh_pkg::*;

    localparam int SECTORS      = 16;
    localparam int COUNT_BITS   = 32;
    localparam int NUM_BINS     = SECTORS * SPEED_CLASSES;
    localparam int RANDOM_ITEMS = 1330;
    localparam int TAIL_ITEMS   = 150;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    // upper limit of speed classes 0..5 in 1/16 unit
    localparam int SPEED_LIMITS [6] = '{0, 32, 48, 80, 112, 144};
    localparam int HOT_SECTOR [2] = '{3, 12};
    localparam int HOT_CLASS  [2] = '{4, 6};

    logic     i_clk;
    logic     i_rst_n;
    logic     i_req_valid;
    logic     o_req_stall;
    t_wrh_req i_req;
    logic     o_rsp_valid;
    logic     i_rsp_stall;
    t_wrh_rsp o_rsp;

    t_wrh_req                sample_queue [$];
    t_wrh_rsp                expected_counts [$];
    logic [COUNT_BITS-1:0]   bin_tally [NUM_BINS];
    int                      mismatches = 0;
    int                      gap_left = 0;
    int                      stall_left = 0;
    int                      stuck_cycles = 0;
    logic                    idle_mix = 1'b1;
    logic                    tail_phase;

    wind_rose_histogram #(
        .SECTORS    (SECTORS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    assign tail_phase = (sample_queue.size() < TAIL_ITEMS);

    // updates the counter table for an add and returns the response a request owes
    function automatic t_wrh_rsp tally_request(input t_wrh_req r);
        t_wrh_rsp    rsp;
        int unsigned d;
        int unsigned sec;
        int unsigned cls;
        int          idx;
        rsp = '0;
        if (r.op == OP_ADD) begin
            cls = 0;
            for (int i = 0; i < 6; i++) begin
                if (int'($signed(r.speed)) > SPEED_LIMITS[i]) begin
                    cls = i + 1;
                end
            end
            d = r.direction;
            if (d >= 5760) begin
                d = d - 5760;
            end
            sec = (d * SECTORS) / 5760;
            idx = sec * SPEED_CLASSES + cls;
            if (bin_tally[idx] != COUNT_MAX) begin
                bin_tally[idx] = bin_tally[idx] + 1'b1;
            end
            rsp.count = 32'(bin_tally[idx]);
        end else begin
            sec = r.read_sector;
            cls = r.read_speed_class;
            if (sec < SECTORS && cls < SPEED_CLASSES) begin
                rsp.count = 32'(bin_tally[sec * SPEED_CLASSES + cls]);
            end
        end
        rsp.speed_class = 3'(cls);
        rsp.sector      = 4'(sec);
        return rsp;
    endfunction

    function automatic int pick_speed(input int cls);
        int s;
        case (cls)
            0:       s = -int'($urandom_range(0, 32768));
            6:       s = int'($urandom_range(145, 32767));
            default: s = int'($urandom_range(SPEED_LIMITS[cls-1] + 1, SPEED_LIMITS[cls]));
        endcase
        return s;
    endfunction

    // sometimes uses the wrapped form past a full turn where it exists
    function automatic int pick_direction(input int sec);
        int d;
        d = sec * 360 + int'($urandom_range(0, 359));
        if (d < 8192 - 5760 && $urandom_range(0, 2) == 0) begin
            d = d + 5760;
        end
        return d;
    endfunction

    task automatic push_add(input int spd, input int dir);
        t_wrh_req r;
        r.op               = OP_ADD;
        r.speed            = 16'(spd);
        r.direction        = 13'(dir);
        r.read_sector      = 4'($urandom);
        r.read_speed_class = 3'($urandom);
        sample_queue.push_back(r);
    endtask

    task automatic push_read(input int sec, input int cls);
        t_wrh_req r;
        r.op               = OP_READ;
        r.speed            = 16'($urandom);
        r.direction        = 13'($urandom);
        r.read_sector      = 4'(sec);
        r.read_speed_class = 3'(cls);
        sample_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && !o_req_stall) begin
                expected_counts.push_back(tally_request(i_req));
                if ($urandom_range(0, 49) == 0) begin
                    idle_mix <= ~idle_mix;
                end
            end
            if (!i_req_valid || !o_req_stall) begin
                if (gap_left > 0) begin
                    i_req_valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end else if (sample_queue.size() > 0) begin
                    i_req       <= sample_queue.pop_front();
                    i_req_valid <= 1'b1;
                    if (!tail_phase && idle_mix && $urandom_range(0, 7) == 0) begin
                        gap_left <= $urandom_range(1, 7);
                    end
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and stall generator
    always @(posedge i_clk) begin
        t_wrh_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("unexpected response, count", o_rsp.count, 0);
            end else begin
                want = expected_counts.pop_front();
                if (o_rsp.count !== want.count) begin
                    report_mismatch("count", o_rsp.count, want.count);
                end
                if (o_rsp.speed_class !== want.speed_class) begin
                    report_mismatch("speed_class", o_rsp.speed_class, want.speed_class);
                end
                if (o_rsp.sector !== want.sector) begin
                    report_mismatch("sector", o_rsp.sector, want.sector);
                end
            end
        end
        if (stall_left > 0) begin
            i_rsp_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (i_rst_n && !tail_phase && idle_mix && $urandom_range(0, 9) == 0) begin
            i_rsp_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int pick;
        int h;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_rsp_stall = 1'b0;
        foreach (bin_tally[i]) begin
            bin_tally[i] = '0;
        end

        // class limits, sector limits and direction wrap
        push_read(0, 0);
        push_add(-32768, 0);
        push_add(0, 5759);
        push_add(1, 359);
        push_add(32, 360);
        push_add(33, 5760);
        push_add(48, 8191);
        push_add(49, 4096);
        push_add(80, 2879);
        push_add(81, 2880);
        push_add(112, 5400);
        push_add(113, 5399);
        push_add(144, 1);
        push_add(145, 5761);
        push_add(32767, 4095);
        // back to back updates of one counter
        push_add(100, 1000);
        push_add(100, 1000);
        push_add(100, 1000);
        push_read(2, 4);
        push_read(0, 0);
        // class index past the table, then the last sector in range
        push_read(15, 7);
        push_read(0, 7);
        push_read(15, 0);

        // two hot bins take a large share of the samples
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            h    = $urandom_range(0, 1);
            if (pick < 15) begin
                if ($urandom_range(0, 2) == 0) begin
                    push_read(HOT_SECTOR[h], HOT_CLASS[h]);
                end else begin
                    push_read($urandom_range(0, 15), $urandom_range(0, 7));
                end
            end else if (pick < 60) begin
                push_add(pick_speed(HOT_CLASS[h]), pick_direction(HOT_SECTOR[h]));
            end else if (pick < 80) begin
                push_add(int'($urandom_range(0, 65535)), int'($urandom_range(0, 8191)));
            end else begin
                push_add(pick_speed($urandom_range(0, 6)), pick_direction($urandom_range(0, 15)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (!(sample_queue.size() == 0 && !i_req_valid && expected_counts.size() == 0)
                   && stuck_cycles < STUCK_LIMIT);

        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
            $display("Simulation FAILED");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (mismatches == 0 && expected_counts.size() == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule

/* files.f */
hdl/wrh_pkg.sv
hdl/wrh_count_store.sv
hdl/wind_rose_histogram.sv
tb/wind_rose_histogram_tb.sv
